// ----- hdl/sjf_pkg.sv -----
// types and constants shared by the shortest-job-first scheduler modules
package sjf_pkg;

  localparam int JOB_ID_W   = 8;
  localparam int RUNTIME_W  = 10;
  localparam int QUANTUM_W  = 16;
  localparam int COMPLETE_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ADMISSION_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_TOTAL       = 1'b1;

  localparam logic [QUANTUM_W-1:0]  ADMISSION_LIMIT_RESET = 16'd100;
  localparam logic [COMPLETE_W-1:0] JOB_TOTAL_RESET       = 8'd0;
  localparam logic [QUANTUM_W-1:0]  QUANTUM_MAX           = 16'hFFFF;
  localparam logic [COMPLETE_W-1:0] COMPLETE_MAX          = 8'hFF;

  typedef struct packed {
    logic                 operation;
    logic [JOB_ID_W-1:0]  job_id;
    logic [RUNTIME_W-1:0] job_runtime;
  } sjf_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 served_valid;
    logic [JOB_ID_W-1:0]  served_job;
    logic                 first_run;
    logic                 job_done;
    logic [QUANTUM_W-1:0] quantum_now;
    logic                 halted;
  } sjf_result_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } sjf_state_t;

  typedef struct packed {
    logic load;
    logic arrive;
    logic tick;
  } sjf_cmd_t;

  typedef struct packed {
    logic tick_op;
  } sjf_status_t;

endpackage

// ----- hdl/sjf_ctrl.sv -----
// controller state machine: accepts an item and sequences one execute step
module sjf_ctrl
  import sjf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  sjf_status_t status,
  output sjf_cmd_t    cmd,
  output logic        busy
);

  sjf_state_t state;
  sjf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        busy       = 1'b1;
        cmd.arrive = (status.tick_op == OP_ARRIVE);
        cmd.tick   = (status.tick_op == OP_TICK);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/sjf_datapath.sv -----
// datapath: sorted run queue cells, counters, config registers and result register
module sjf_datapath
  import sjf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sjf_cmd_t              cmd,
  input  sjf_item_t             item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sjf_status_t           status,
  output sjf_result_t           result,
  output logic                  result_valid
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [JOB_ID_W-1:0]   slot_job     [QUEUE_DEPTH];
  logic [RUNTIME_W-1:0]  slot_runtime [QUEUE_DEPTH];

  logic [OCC_W-1:0]      occupancy;
  logic [OCC_W-1:0]      occupancy_next;
  logic [RUNTIME_W-1:0]  head_executed;
  logic [RUNTIME_W-1:0]  head_executed_next;
  logic [QUANTUM_W-1:0]  quantum_count;
  logic [QUANTUM_W-1:0]  quantum_count_next;
  logic [COMPLETE_W-1:0] completed_count;
  logic [COMPLETE_W-1:0] completed_count_next;
  logic                  stopped;
  logic                  stopped_next;
  logic [QUANTUM_W-1:0]  admission_limit;
  logic [COMPLETE_W-1:0] job_total;

  logic                  op;
  logic [JOB_ID_W-1:0]   new_id;
  logic [RUNTIME_W-1:0]  new_runtime;
  logic [QUEUE_DEPTH-1:0] gt_now;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] ins_after;

  logic                  arrive_ok;
  logic                  insert;
  logic                  pop;
  logic [RUNTIME_W:0]    head_sum;
  logic                  head_done;
  logic                  limit_hit;
  logic [COMPLETE_W-1:0] completed_inc;
  logic                  advance;
  sjf_result_t           result_next;

  assign status.tick_op = op;

  // compare against the arriving runtime while the item is taken
  always_comb begin
    gt_now = '0;
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      gt_now[k] = slot_runtime[k] > item.job_runtime;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op          <= item.operation;
      new_id      <= item.job_id;
      new_runtime <= item.job_runtime;
      gt          <= gt_now;
    end
  end

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      ins_after[k] = (OCC_W'(k) >= occupancy) || ((k != 0) && gt[k]);
    end
  end

  assign arrive_ok = !stopped && (quantum_count < admission_limit)
                     && (occupancy < OCC_W'(QUEUE_DEPTH));
  assign insert    = cmd.arrive && arrive_ok;
  assign head_sum  = {1'b0, head_executed} + {{RUNTIME_W{1'b0}}, 1'b1};
  assign head_done = (occupancy != '0) && (head_sum >= {1'b0, slot_runtime[0]});
  assign pop       = cmd.tick && !stopped && head_done;
  assign limit_hit = quantum_count >= admission_limit;
  assign completed_inc = (completed_count == COMPLETE_MAX) ? completed_count
                         : completed_count + COMPLETE_W'(1);

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == QUEUE_DEPTH - 1) ? g : g + 1;
    logic first_slot;
    assign first_slot = (g == 0) || !ins_after[PREV];

    always_ff @(posedge clk) begin
      if (insert && ins_after[g]) begin
        if (first_slot) begin
          slot_job[g]     <= new_id;
          slot_runtime[g] <= new_runtime;
        end else begin
          slot_job[g]     <= slot_job[PREV];
          slot_runtime[g] <= slot_runtime[PREV];
        end
      end else if (pop) begin
        slot_job[g]     <= slot_job[NEXT];
        slot_runtime[g] <= slot_runtime[NEXT];
      end
    end
  end

  always_comb begin
    occupancy_next       = occupancy;
    head_executed_next   = head_executed;
    quantum_count_next   = quantum_count;
    completed_count_next = completed_count;
    stopped_next         = stopped;
    advance              = 1'b0;
    result_next             = '0;
    result_next.quantum_now = quantum_count;
    if (cmd.arrive) begin
      result_next.accepted = arrive_ok;
      if (arrive_ok) begin
        occupancy_next = occupancy + OCC_W'(1);
      end
    end else if (cmd.tick && !stopped) begin
      advance = 1'b1;
      if (occupancy != '0) begin
        result_next.served_valid = 1'b1;
        result_next.served_job   = slot_job[0];
        result_next.first_run    = (head_executed == '0);
        head_executed_next       = head_sum[RUNTIME_W-1:0];
        if (head_done) begin
          result_next.job_done = 1'b1;
          occupancy_next       = occupancy - OCC_W'(1);
          head_executed_next   = '0;
          completed_count_next = completed_inc;
          if (limit_hit) begin
            occupancy_next = '0;
            stopped_next   = 1'b1;
            advance        = 1'b0;
          end else if ((job_total != '0) && (completed_inc >= job_total)) begin
            stopped_next = 1'b1;
          end
        end
      end else if (limit_hit) begin
        stopped_next = 1'b1;
        advance      = 1'b0;
      end
      if (advance && (quantum_count != QUANTUM_MAX)) begin
        quantum_count_next = quantum_count + QUANTUM_W'(1);
      end
    end
    result_next.halted = stopped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy       <= '0;
      head_executed   <= '0;
      quantum_count   <= '0;
      completed_count <= '0;
      stopped         <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      occupancy       <= occupancy_next;
      head_executed   <= head_executed_next;
      quantum_count   <= quantum_count_next;
      completed_count <= completed_count_next;
      stopped         <= stopped_next;
      result_valid    <= cmd.arrive || cmd.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arrive || cmd.tick) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      admission_limit <= ADMISSION_LIMIT_RESET;
      job_total       <= JOB_TOTAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ADMISSION_LIMIT: admission_limit <= cfg_data;
        CFG_JOB_TOTAL:       job_total       <= cfg_data[COMPLETE_W-1:0];
        default: begin
          admission_limit <= admission_limit;
        end
      endcase
    end
  end

endmodule

// ----- hdl/nonpreemptive_sjf_scheduler_unit.sv -----
// top level of the non-preemptive shortest-job-first run queue
// usage:
//   drive item and raise start while busy is low; the item is taken at that edge
//   an arrive item inserts a job behind all jobs of equal or shorter runtime,
//   never ahead of the running head job
//   a tick item runs the head job for one quantum and reports first run and done
//   each item gives exactly one result, shown on result for one cycle with
//   result_valid high; the receiver cannot stall the block
// sequence:
//   the load step takes the item and compares its runtime against every queue
//   cell but the head; the execute step shifts the cells and updates the counters;
//   the result appears in the cycle after that, and the edge that ends it can
//   already take a new start, but a start during the execute step is not taken
// configuration:
//   cfg_write with cfg_index 0 sets admission_limit, 1 sets job_total
//   write only while busy is low and no result is pending
// reset:
//   rst clears the queue, all counters and the halt flag; admission_limit goes
//   to 100 and job_total to 0; no clearing pass is needed
module nonpreemptive_sjf_scheduler_unit
  import sjf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  sjf_item_t             item,
  output logic                  busy,
  output sjf_result_t           result,
  output logic                  result_valid,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sjf_cmd_t    cmd;
  sjf_status_t status;

  sjf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sjf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the shortest-job-first run queue, with a cycle-free predictor
module tb;
  import sjf_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int CLK_HALF      = 5;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 400;
  localparam int N_DIRECTED    = 24;
  localparam logic [QUANTUM_W-1:0] LIMIT_MARGIN = 16'd24;

  typedef struct packed {
    sjf_item_t   it;
    logic        fixed;
    sjf_result_t want;
  } step_row_t;

  // fixed expectations: reset state, first arrivals, full queue, first head job
  localparam step_row_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_TICK,   8'h00, 10'd0},    1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0}},
    '{'{OP_ARRIVE, 8'hFF, 10'd3},    1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1, 1'b0}},
    '{'{OP_ARRIVE, 8'h00, 10'd1023}, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1, 1'b0}},
    '{'{OP_ARRIVE, 8'h01, 10'd0},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h02, 10'd5},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h03, 10'd5},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h04, 10'd0},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h55, 10'd1},    1'b0, '0},
    '{'{OP_ARRIVE, 8'hAA, 10'd2},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h0F, 10'd4},    1'b0, '0},
    '{'{OP_ARRIVE, 8'hF0, 10'd8},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h33, 10'd1},    1'b0, '0},
    '{'{OP_ARRIVE, 8'hCC, 10'd2},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h5A, 10'd6},    1'b0, '0},
    '{'{OP_ARRIVE, 8'hA5, 10'd3},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h81, 10'd9},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h7E, 10'd7},    1'b0, '0},
    '{'{OP_ARRIVE, 8'h99, 10'd2},    1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1, 1'b0}},
    '{'{OP_TICK,   8'h00, 10'd0},    1'b1, '{1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 16'd1, 1'b0}},
    '{'{OP_TICK,   8'h00, 10'd0},    1'b0, '0},
    '{'{OP_TICK,   8'h00, 10'd0},    1'b1, '{1'b0, 1'b1, 8'hFF, 1'b0, 1'b1, 16'd3, 1'b0}},
    '{'{OP_TICK,   8'h00, 10'd0},    1'b0, '0},
    '{'{OP_TICK,   8'h00, 10'd0},    1'b0, '0},
    '{'{OP_TICK,   8'h00, 10'd0},    1'b0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  start;
  sjf_item_t             item;
  logic                  busy;
  sjf_result_t           result;
  logic                  result_valid;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // scheduler state as predicted
  logic [JOB_ID_W-1:0]   slot_job_m [QUEUE_DEPTH];
  logic [RUNTIME_W-1:0]  slot_rt_m  [QUEUE_DEPTH];
  int                    occ_m;
  logic [RUNTIME_W-1:0]  head_runs_m;
  logic [QUANTUM_W-1:0]  quantum_m;
  logic [COMPLETE_W-1:0] done_m;
  logic                  halted_m;
  logic [QUANTUM_W-1:0]  limit_m;
  logic [COMPLETE_W-1:0] total_m;

  sjf_result_t expected_results [$];
  sjf_result_t want;
  int          idle_pct;
  int          mismatches;
  int          results_checked;
  int          transfers;
  string       end_case;

  nonpreemptive_sjf_scheduler_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result(result),
    .result_valid(result_valid),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(CLK_HALF * 2 * 2_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic void clear_schedule();
    occ_m       = 0;
    head_runs_m = '0;
    quantum_m   = '0;
    done_m      = '0;
    halted_m    = 1'b0;
    limit_m     = ADMISSION_LIMIT_RESET;
    total_m     = JOB_TOTAL_RESET;
  endfunction

  function automatic sjf_result_t schedule_step(input sjf_item_t it);
    sjf_result_t r;
    int          pos;
    int          k;
    logic        advance;
    r = '0;
    r.quantum_now = quantum_m;
    advance = 1'b1;
    if (it.operation == OP_ARRIVE) begin
      if (!halted_m && quantum_m < limit_m && occ_m < QUEUE_DEPTH) begin
        pos = occ_m;
        for (k = 1; k < occ_m; k++) begin
          if (slot_rt_m[k] > it.job_runtime) begin
            pos = k;
            break;
          end
        end
        for (k = occ_m; k > pos; k--) begin
          slot_job_m[k] = slot_job_m[k-1];
          slot_rt_m[k]  = slot_rt_m[k-1];
        end
        slot_job_m[pos] = it.job_id;
        slot_rt_m[pos]  = it.job_runtime;
        occ_m++;
        r.accepted = 1'b1;
      end
    end else if (!halted_m) begin
      if (occ_m != 0) begin
        r.served_valid = 1'b1;
        r.served_job   = slot_job_m[0];
        r.first_run    = (head_runs_m == '0);
        head_runs_m++;
        if (head_runs_m >= slot_rt_m[0]) begin
          r.job_done = 1'b1;
          for (k = 1; k < occ_m; k++) begin
            slot_job_m[k-1] = slot_job_m[k];
            slot_rt_m[k-1]  = slot_rt_m[k];
          end
          occ_m--;
          head_runs_m = '0;
          if (done_m != COMPLETE_MAX) done_m++;
          if (quantum_m >= limit_m) begin
            // completion once the clock has reached the limit flushes everything
            occ_m    = 0;
            halted_m = 1'b1;
            advance  = 1'b0;
          end else if (total_m != '0 && done_m >= total_m) begin
            halted_m = 1'b1;
          end
        end
      end else if (quantum_m >= limit_m) begin
        halted_m = 1'b1;
        advance  = 1'b0;
      end
      if (advance && quantum_m != QUANTUM_MAX) quantum_m++;
    end
    r.halted = halted_m;
    return r;
  endfunction

  function automatic sjf_item_t random_item(input int arrive_pct, input int rt_hi);
    sjf_item_t it;
    int        r;
    it.operation = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_TICK;
    it.job_id    = JOB_ID_W'($urandom_range(255));
    r = $urandom_range(999);
    if (rt_hi >= 0) it.job_runtime = RUNTIME_W'($urandom_range(rt_hi));
    else if (r < 5) it.job_runtime = RUNTIME_W'($urandom_range(1023));
    else if (r < 105) it.job_runtime = RUNTIME_W'($urandom_range(31));
    else it.job_runtime = RUNTIME_W'($urandom_range(6));
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input sjf_item_t it, input logic fixed, input sjf_result_t fixed_want);
    sjf_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = schedule_step(it);
    expected_results.push_back(fixed ? fixed_want : predicted);
    transfers++;
    @(negedge clk);
  endtask

  task automatic send_random(input int arrive_pct, input int rt_hi);
    send_item(random_item(arrive_pct, rt_hi), 1'b0, '0);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == CFG_ADMISSION_LIMIT) limit_m = val;
    else total_m = val[COMPLETE_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer: got %h", $time, result);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("accepted", want.accepted, result.accepted);
        check_field("served_valid", want.served_valid, result.served_valid);
        check_field("served_job", want.served_job, result.served_job);
        check_field("first_run", want.first_run, result.first_run);
        check_field("job_done", want.job_done, result.job_done);
        check_field("quantum_now", want.quantum_now, result.quantum_now);
        check_field("halted", want.halted, result.halted);
      end
    end
  end

  initial begin
    int wait_cycles;
    rst             = 1'b1;
    start           = 1'b0;
    item            = '0;
    cfg_write       = 1'b0;
    cfg_index       = CFG_ADMISSION_LIMIT;
    cfg_data        = '0;
    idle_pct        = 0;
    mismatches      = 0;
    results_checked = 0;
    transfers       = 0;
    clear_schedule();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED[i].it, DIRECTED[i].fixed, DIRECTED[i].want);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CFG_ADMISSION_LIMIT, QUANTUM_MAX);
          write_reg(CFG_JOB_TOTAL, 16'(COMPLETE_MAX));
          idle_pct = 0;
        end
        1: begin
          write_reg(CFG_JOB_TOTAL, 16'(JOB_TOTAL_RESET));
          idle_pct = 50;
        end
        2: begin
          // refusals past the limit, arrivals only so the block keeps running
          idle_pct = 0;
          write_reg(CFG_ADMISSION_LIMIT, 16'd0);
          repeat (4) send_random(100, -1);
          settle();
          write_reg(CFG_ADMISSION_LIMIT, 16'd1);
          repeat (2) send_random(100, -1);
          settle();
          write_reg(CFG_ADMISSION_LIMIT, quantum_m);
          repeat (2) send_random(100, -1);
          settle();
          write_reg(CFG_ADMISSION_LIMIT, quantum_m + 16'd1);
          repeat (2) send_random(100, -1);
          settle();
          write_reg(CFG_ADMISSION_LIMIT, 16'd40000);
        end
        default: begin
          write_reg(CFG_ADMISSION_LIMIT, QUANTUM_MAX);
          idle_pct = 35;
        end
      endcase
      repeat (PHASE_ITEMS) send_random(35, -1);
    end

    // drain the queue, then pull the limit in just ahead of the clock
    idle_pct = 0;
    while (occ_m != 0 && !halted_m) send_item('{OP_TICK, 8'h00, 10'd0}, 1'b0, '0);

    settle();
    write_reg(CFG_ADMISSION_LIMIT, quantum_m + LIMIT_MARGIN);
    idle_pct = 35;
    case ($urandom_range(2))
      0: begin
        end_case = "flush at the limit";
        while (!halted_m) send_random(40, 40);
      end
      1: begin
        end_case = "idle past the limit";
        while (!halted_m) send_random(0, 0);
      end
      default: begin
        end_case = "job total reached";
        write_reg(CFG_JOB_TOTAL, (done_m > COMPLETE_MAX - 8'd2) ? 16'(COMPLETE_MAX)
                                                                  : 16'(done_m + 8'd2));
        while (!halted_m) send_random(50, 3);
      end
    endcase
    repeat (12) send_random(50, -1);

    start <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 1000 && expected_results.size() != 0; wait_cycles++)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end

    $display("ran %0d transfers, checked %0d results, %0d mismatches",
             transfers, results_checked, mismatches);
    $display("clock reached quantum %0d, %0d jobs completed, run ended by %s",
             quantum_m, done_m, end_case);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
